// ----- hdl/mmpi_pkg.sv -----
// Package for the multimodal position-id block: widths, queue entry type,
// configuration register indexes. No dependencies.
package mmpi_pkg;

  localparam int TOK_W   = 20;
  localparam int GRID_W  = 11;
  localparam int SPAN_W  = 10;
  localparam int POS_W   = 16;
  localparam int MS_W    = 4;
  localparam int CFG_W   = 20;
  localparam int DIV_CNT_W = 4;

  localparam logic [SPAN_W-1:0] SPAN_MAX = 10'd1023;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd11;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic CFG_VISION_START = 1'b0;
  localparam logic CFG_MERGE_FACTOR = 1'b1;

  typedef struct packed {
    logic              seq_first;
    logic              is_start;
    logic [SPAN_W-1:0] rows;
    logic [SPAN_W-1:0] cols;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hdl/mmpi_div.sv -----
// Restoring divider, one quotient bit per cycle, for grid size / merge size.
// Depends on mmpi_pkg.
module mmpi_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mmpi_pkg::GRID_W-1:0] dividend,
  input  logic [mmpi_pkg::MS_W-1:0]   divisor,
  output logic                       done,
  output logic [mmpi_pkg::GRID_W-1:0] quotient
);
  import mmpi_pkg::*;

  logic [MS_W-1:0]      rem;
  logic [MS_W-1:0]      dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MS_W:0]        shifted;
  logic                 fits;

  assign shifted = {rem, quotient[GRID_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= MS_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[MS_W-1:0];
      end
      quotient <= {quotient[GRID_W-2:0], fits};
    end
  end

endmodule

// ----- hdl/mmpi_front.sv -----
// Front end: accepts tokens, flags vision-start tokens and divides their grid.
// Depends on mmpi_pkg and mmpi_div.
module mmpi_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mmpi_pkg::CFG_W-1:0]  vision_start_id,
  input  logic [mmpi_pkg::MS_W-1:0]   merge_factor,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mmpi_pkg::TOK_W-1:0]  token_id,
  input  logic                        seq_first,
  input  logic                        image_present,
  input  logic [mmpi_pkg::GRID_W-1:0] grid_rows,
  input  logic [mmpi_pkg::GRID_W-1:0] grid_cols,
  input  mmpi_pkg::q_status_t         q_status,
  output logic                        push,
  output mmpi_pkg::entry_t            push_entry
);
  import mmpi_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t           state;
  logic              hold_first;
  logic              is_start;
  logic              accept;
  logic              div_start;
  logic              div_done_r;
  logic              div_done_c;
  logic [MS_W-1:0]   divisor;
  logic [GRID_W-1:0] q_rows;
  logic [GRID_W-1:0] q_cols;
  logic [SPAN_W-1:0] sat_rows;
  logic [SPAN_W-1:0] sat_cols;

  assign is_start  = (token_id == vision_start_id) && image_present;
  assign in_ready  = (state == F_IDLE) && !q_status.full;
  assign accept    = in_valid && in_ready;
  assign div_start = accept && is_start;
  // zero merge size divides by one
  assign divisor   = (merge_factor == '0) ? MS_W'(1) : merge_factor;

  mmpi_div u_div_rows (
    .clk(clk), .rst(rst), .start(div_start), .dividend(grid_rows),
    .divisor(divisor), .done(div_done_r), .quotient(q_rows)
  );

  mmpi_div u_div_cols (
    .clk(clk), .rst(rst), .start(div_start), .dividend(grid_cols),
    .divisor(divisor), .done(div_done_c), .quotient(q_cols)
  );

  // saturate merged size
  assign sat_rows = (q_rows > GRID_W'(SPAN_MAX)) ? SPAN_MAX : q_rows[SPAN_W-1:0];
  assign sat_cols = (q_cols > GRID_W'(SPAN_MAX)) ? SPAN_MAX : q_cols[SPAN_W-1:0];

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    unique case (state)
      F_IDLE: begin
        push                 = accept && !is_start;
        push_entry.seq_first = seq_first;
      end
      F_PUSH: begin
        push                 = !q_status.full;
        push_entry.seq_first = hold_first;
        push_entry.is_start  = 1'b1;
        push_entry.rows      = sat_rows;
        push_entry.cols      = sat_cols;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (div_start) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_done_r && div_done_c) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_status.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      hold_first <= seq_first;
    end
  end

endmodule

// ----- hdl/mmpi_fifo.sv -----
// Short queue of classified tokens between front and back end.
// Depends on mmpi_pkg.
module mmpi_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mmpi_pkg::entry_t    push_entry,
  input  logic                pop,
  output mmpi_pkg::entry_t    head,
  output mmpi_pkg::q_status_t status
);
  import mmpi_pkg::*;

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hdl/mmpi_back.sv -----
// Back end: numbers queued tokens, walks image spans, holds the output register.
// Depends on mmpi_pkg.
module mmpi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mmpi_pkg::entry_t           head,
  input  mmpi_pkg::q_status_t        q_status,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mmpi_pkg::POS_W-1:0] time_pos,
  output logic [mmpi_pkg::POS_W-1:0] height_pos,
  output logic [mmpi_pkg::POS_W-1:0] width_pos
);
  import mmpi_pkg::*;

  logic [POS_W-1:0]  running_pos, running_pos_next;
  logic              in_image, in_image_next;
  logic [SPAN_W-1:0] span_rows, span_rows_next;
  logic [SPAN_W-1:0] span_cols, span_cols_next;
  logic [SPAN_W-1:0] row_index, row_index_next;
  logic [SPAN_W-1:0] col_index, col_index_next;

  logic [POS_W-1:0]  pos;
  logic              img;
  logic [SPAN_W-1:0] r_i;
  logic [SPAN_W-1:0] c_i;
  logic [SPAN_W:0]   r_inc;
  logic [SPAN_W:0]   c_inc;
  logic [SPAN_W-1:0] span_adv;
  logic [SPAN_W-1:0] new_adv;
  logic [POS_W-1:0]  t_val, h_val, w_val;

  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_comb begin
    pos = running_pos;
    img = in_image;
    r_i = row_index;
    c_i = col_index;
    if (head.seq_first) begin
      pos = '0;
      img = 1'b0;
      r_i = '0;
      c_i = '0;
    end
    r_inc    = {1'b0, r_i} + 1'b1;
    c_inc    = {1'b0, c_i} + 1'b1;
    span_adv = (span_rows > span_cols) ? span_rows : span_cols;
    new_adv  = (head.rows > head.cols) ? head.rows : head.cols;

    running_pos_next = pos;
    in_image_next    = img;
    span_rows_next   = span_rows;
    span_cols_next   = span_cols;
    row_index_next   = r_i;
    col_index_next   = c_i;

    if (img) begin
      t_val = pos;
      h_val = pos + POS_W'(r_i);
      w_val = pos + POS_W'(c_i);
      if (c_inc >= {1'b0, span_cols}) begin
        col_index_next = '0;
        if (r_inc >= {1'b0, span_rows}) begin
          running_pos_next = pos + POS_W'(span_adv);
          in_image_next    = 1'b0;
          row_index_next   = '0;
        end else begin
          row_index_next = r_inc[SPAN_W-1:0];
        end
      end else begin
        col_index_next = c_inc[SPAN_W-1:0];
      end
    end else begin
      t_val            = pos;
      h_val            = pos;
      w_val            = pos;
      running_pos_next = pos + 1'b1;
      if (head.is_start) begin
        span_rows_next = head.rows;
        span_cols_next = head.cols;
        row_index_next = '0;
        col_index_next = '0;
        if (head.rows != '0 && head.cols != '0) begin
          in_image_next = 1'b1;
        end else begin
          // empty grid: advance at once
          running_pos_next = pos + POS_W'(new_adv) + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_pos <= '0;
      in_image    <= 1'b0;
      span_rows   <= '0;
      span_cols   <= '0;
      row_index   <= '0;
      col_index   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        running_pos <= running_pos_next;
        in_image    <= in_image_next;
        span_rows   <= span_rows_next;
        span_cols   <= span_cols_next;
        row_index   <= row_index_next;
        col_index   <= col_index_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      time_pos   <= t_val;
      height_pos <= h_val;
      width_pos  <= w_val;
    end
  end

endmodule

// ----- hdl/multimodal_position_ids.sv -----
// Multimodal position ids: time, height and width id for every token.
// A text or image token enters the queue when accepted and loads the result register
// at the queue head once the output is free. A vision-start token with an image holds
// the input for 11 divider steps, the done check (F_DIV) and the push (F_PUSH).
// Otherwise one token per cycle while the queue is not full.
// Reset (rst, synchronous): running position and span state cleared,
// queue emptied, vision_start_id = 0, merge factor = 2.
module multimodal_position_ids (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  // token input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // token_id[19:0], grid_rows[30:20], grid_cols[41:31], zero pad
  input  logic [1:0]  s_tuser,   // seq_first[0], image_present[1]
  // position output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // time_pos[15:0], height_pos[31:16], width_pos[47:32]
);
  import mmpi_pkg::*;

  logic [CFG_W-1:0] vision_start_id;
  logic [MS_W-1:0]  merge_factor;

  logic      push;
  entry_t    push_entry;
  entry_t    head;
  q_status_t q_status;
  logic      pop;

  logic [POS_W-1:0] time_pos;
  logic [POS_W-1:0] height_pos;
  logic [POS_W-1:0] width_pos;

  // Configuration registers: write only while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vision_start_id <= '0;
      merge_factor    <= MS_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VISION_START: vision_start_id <= cfg_data;
        CFG_MERGE_FACTOR: merge_factor    <= cfg_data[MS_W-1:0];
        default:          merge_factor    <= merge_factor;
      endcase
    end
  end

  // Front end: classify, divide the image grid, push into the queue.
  mmpi_front u_front (
    .clk             (clk),
    .rst             (rst),
    .vision_start_id (vision_start_id),
    .merge_factor    (merge_factor),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .token_id        (s_tdata[19:0]),
    .seq_first       (s_tuser[0]),
    .image_present   (s_tuser[1]),
    .grid_rows       (s_tdata[30:20]),
    .grid_cols       (s_tdata[41:31]),
    .q_status        (q_status),
    .push            (push),
    .push_entry      (push_entry)
  );

  // Queue decouples the divider stall from the numbering.
  mmpi_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back end: hold running position and span walk, drive the output register.
  mmpi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .time_pos   (time_pos),
    .height_pos (height_pos),
    .width_pos  (width_pos)
  );

  assign m_tdata = {width_pos, height_pos, time_pos};

endmodule

// ----- sim/multimodal_position_ids_tb.sv -----
// Self-checking testbench for multimodal_position_ids: drives token transactions,
// predicts time/height/width ids and checks every result transaction in order.
// Depends on mmpi_pkg (configuration register indexes) and the block itself.
`timescale 1ns / 100ps

module multimodal_position_ids_tb;
  import mmpi_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT = 30;    // extra cycles after the last result

  // One token as the sender sees it
  typedef struct {
    logic [19:0] tok;
    logic        first;
    logic        present;
    logic [10:0] rows;
    logic [10:0] cols;
  } token_t;

  // Position ids of one result
  typedef struct packed {
    logic [15:0] t;
    logic [15:0] h;
    logic [15:0] w;
  } pos_ids_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_VISION_START;
  logic [19:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // token_id[19:0], grid_rows[30:20], grid_cols[41:31], zero pad
  logic [1:0]  s_tuser = '0;   // seq_first[0], image_present[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // time_pos[15:0], height_pos[31:16], width_pos[47:32]

  multimodal_position_ids u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Position numbering state, mirrored from the block
  // ---------------------------------------------------------------------------
  logic [19:0] vsid_q  = '0;     // vision_start_id copy
  logic [3:0]  merge_q = 4'd2;   // merge factor copy
  logic [15:0] run_pos = '0;
  logic        in_span = 1'b0;
  logic [9:0]  span_r  = '0;
  logic [9:0]  span_c  = '0;
  logic [9:0]  row_idx = '0;
  logic [9:0]  col_idx = '0;

  token_t   token_fifo[$];    // tokens waiting to be driven
  pos_ids_t expected_ids[$];  // ids owed by the block, oldest first
  int       issued   = 0;     // tokens pushed into token_fifo
  int       accepted = 0;     // token transactions completed
  int       errors   = 0;
  int       idle_cycles = 0;

  function automatic int eff_merge();
    return (merge_q == 4'd0) ? 1 : int'(merge_q);
  endfunction

  // Divide a patch grid dimension by the merge factor, saturate to 10 bits
  function automatic logic [9:0] merge_dim(input logic [10:0] dim);
    int q;
    q = int'(dim) / eff_merge();
    return (q > 1023) ? 10'd1023 : q[9:0];
  endfunction

  // Work out the ids of one accepted token and advance the numbering state
  function automatic pos_ids_t number_token(input token_t tk);
    pos_ids_t   p;
    logic [9:0] r;
    logic [9:0] c;
    if (tk.first) begin
      run_pos = '0;
      in_span = 1'b0;
      row_idx = '0;
      col_idx = '0;
    end
    if (in_span) begin
      // Image token: row-major walk of the merged grid around a fixed base
      p.t = run_pos;
      p.h = run_pos + 16'(row_idx);
      p.w = run_pos + 16'(col_idx);
      if (int'(col_idx) + 1 >= int'(span_c)) begin
        col_idx = '0;
        row_idx = row_idx + 10'd1;
        if (row_idx >= span_r) begin
          run_pos = run_pos + 16'((span_r > span_c) ? span_r : span_c);
          in_span = 1'b0;
          row_idx = '0;
        end
      end else begin
        col_idx = col_idx + 10'd1;
      end
      return p;
    end
    p.t = run_pos;
    p.h = run_pos;
    p.w = run_pos;
    run_pos = run_pos + 16'd1;
    if (tk.tok == vsid_q && tk.present) begin
      r = merge_dim(tk.rows);
      c = merge_dim(tk.cols);
      span_r  = r;
      span_c  = c;
      row_idx = '0;
      col_idx = '0;
      // Empty grid opens no span: skip ahead right away
      if (r != 10'd0 && c != 10'd0) in_span = 1'b1;
      else run_pos = run_pos + 16'((r > c) ? r : c);
    end
    return p;
  endfunction

  // Idle length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed token transactions from token_fifo, predict on acceptance
  // ---------------------------------------------------------------------------
  token_t on_bus;
  int     src_gap = 0;
  int     src_burst = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_ids = {expected_ids, number_token(on_bus)};
        accepted++;
      end
      // Bus free for a new token: either idle or the last one just went through
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (token_fifo.size() != 0) begin
          on_bus = token_fifo.pop_front();
          s_tdata  <= {6'b0, on_bus.cols, on_bus.rows, on_bus.tok};
          s_tuser  <= {on_bus.present, on_bus.first};
          s_tvalid <= 1'b1;
          // Hold off the next token, or run a stretch back to back
          if (src_burst > 0) begin
            src_burst--;
          end else begin
            src_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) src_burst = $urandom_range(40, 150);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: apply backpressure, compare each result with the oldest prediction
  // ---------------------------------------------------------------------------
  int       snk_stall = 0;
  int       snk_burst = 0;
  pos_ids_t want;
  pos_ids_t got;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.t = m_tdata[15:0];
        got.h = m_tdata[31:16];
        got.w = m_tdata[47:32];
        if (expected_ids.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result t=%0d h=%0d w=%0d", $time, got.t, got.h, got.w);
        end else begin
          want = expected_ids.pop_front();
          if (got.t !== want.t || got.h !== want.h || got.w !== want.w) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected t=%0d h=%0d w=%0d, got t=%0d h=%0d w=%0d",
                       $time, want.t, want.h, want.w, got.t, got.h, got.w);
          end
        end
      end
      // Stall after some results and at random otherwise
      if (snk_stall > 0) begin
        snk_stall--;
      end else if (snk_burst > 0) begin
        snk_burst--;
      end else if ((m_tvalid && m_tready) || $urandom_range(0, 19) == 0) begin
        snk_stall = pick_gap();
        if ($urandom_range(0, 49) == 0) snk_burst = $urandom_range(40, 150);
      end
      m_tready <= (snk_stall == 0);
    end
  end

  // Watchdog: count cycles in which no transaction completes on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("multimodal_position_ids_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_token(input logic [19:0] tok, input logic first, input logic present,
                           input logic [10:0] rows, input logic [10:0] cols);
    token_t tk;
    tk.tok = tok;
    tk.first = first;
    tk.present = present;
    tk.rows = rows;
    tk.cols = cols;
    token_fifo = {token_fifo, tk};
    issued++;
  endtask

  // Wait until every token has gone in and every result has come out
  task automatic wait_drained();
    while (accepted != issued || expected_ids.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; only call with the block drained
  task automatic write_config(input logic [19:0] vsid, input logic [3:0] ms);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VISION_START;
    cfg_data  <= vsid;
    @(posedge clk);
    cfg_index <= CFG_MERGE_FACTOR;
    cfg_data  <= {16'b0, ms};
    @(posedge clk);
    cfg_we    <= 1'b0;
    vsid_q  = vsid;
    merge_q = ms;
  endtask

  // Random token sequences. In heavy mode most tokens are empty-grid starts with
  // large grids so the running position sweeps past the 16-bit wrap.
  task automatic add_random_tokens(input int n, input bit heavy);
    int          stop_at;
    int          kind;
    int          m;
    int          r;
    int          c;
    int          k;
    logic [19:0] tok;
    logic [10:0] gr;
    logic [10:0] gc;
    stop_at = issued + n;
    while (issued < stop_at) begin
      m = eff_merge();
      kind = $urandom_range(0, 99);
      if (heavy) kind = (kind < 90) ? 80 : (kind < 95) ? 60 : 0;
      if (kind < 45) begin
        // Well-formed image: start token, then exactly rows*cols image tokens
        r = $urandom_range(1, 6);
        c = $urandom_range(1, 6);
        if ($urandom_range(0, 29) == 0) begin
          r = $urandom_range(60, 120);
          c = 1;
          if ($urandom_range(0, 1) == 1) begin
            c = r;
            r = 1;
          end
        end
        gr = 11'(r * m + $urandom_range(0, m - 1));
        gc = 11'(c * m + $urandom_range(0, m - 1));
        add_token(vsid_q, !heavy && $urandom_range(0, 19) == 0, 1'b1, gr, gc);
        for (k = 0; k < r * c; k++) begin
          // Image tokens carry anything, the start id included
          tok = ($urandom_range(0, 9) == 0) ? vsid_q : 20'($urandom());
          add_token(tok, !heavy && $urandom_range(0, 99) == 0, 1'($urandom()),
                    11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
        end
      end else if (kind < 70) begin
        // Text token; ignored grid fields take arbitrary values
        tok = 20'($urandom());
        if (tok == vsid_q) tok = ~tok;
        add_token(tok, !heavy && $urandom_range(0, 49) == 0, 1'($urandom()),
                  11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
      end else if (kind < 82) begin
        // Empty grid: one dimension divides down to zero
        gr = heavy ? 11'($urandom_range(900, 1024)) : 11'($urandom_range(0, 1024));
        gc = ($urandom_range(0, 2) == 0) ? 11'($urandom_range(0, m - 1)) : 11'd0;
        if ($urandom_range(0, 1) == 1) add_token(vsid_q, 1'b0, 1'b1, gc, gr);
        else add_token(vsid_q, 1'b0, 1'b1, gr, gc);
      end else if (kind < 90) begin
        // Start token with no image left
        add_token(vsid_q, !heavy && $urandom_range(0, 19) == 0, 1'b0,
                  11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
      end else begin
        // Noise: any fields, restarts included, never a start id
        tok = 20'($urandom());
        if (tok == vsid_q) tok = tok ^ 20'd1;
        add_token(tok, 1'($urandom()), 1'($urandom()),
                  11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings: start id 0, merge size 2
    add_token(20'h00001, 1'b1, 1'b0, 11'd0, 11'd0);        // restart on a text token
    add_token(20'hFFFFF, 1'b0, 1'b1, 11'd1024, 11'd1024);  // text, grid fields ignored
    add_token(20'h00000, 1'b0, 1'b0, 11'd6, 11'd6);        // start with no image
    add_token(20'h00000, 1'b0, 1'b1, 11'd5, 11'd4);        // 2x2 span
    add_token(20'h00000, 1'b0, 1'b1, 11'd1024, 11'd1024);  // start id inside a span
    add_token(20'hFFFFF, 1'b0, 1'b0, 11'd0, 11'd0);
    add_token(20'h12345, 1'b0, 1'b1, 11'd7, 11'd3);
    add_token(20'h00000, 1'b0, 1'b0, 11'd0, 11'd0);
    add_token(20'h00000, 1'b0, 1'b1, 11'd1, 11'd9);        // rows divide to zero
    add_token(20'h00000, 1'b0, 1'b1, 11'd1024, 11'd0);     // skip ahead by 512
    add_token(20'h00000, 1'b0, 1'b1, 11'd6, 11'd2);        // 3x1 span
    add_token(20'h00007, 1'b0, 1'b0, 11'd0, 11'd0);
    add_token(20'h00008, 1'b1, 1'b0, 11'd0, 11'd0);        // restart inside the span
    add_token(20'h00000, 1'b0, 1'b1, 11'd3, 11'd3);        // 1x1 span
    add_token(20'h00009, 1'b0, 1'b0, 11'd0, 11'd0);
    add_token(20'h0000A, 1'b0, 1'b0, 11'd0, 11'd0);
    add_token(20'h00000, 1'b1, 1'b1, 11'd4, 11'd6);        // restart on a start token
    repeat (6) add_token(20'($urandom()), 1'b0, 1'($urandom()), 11'd0, 11'd0);
    add_token(20'h00055, 1'b0, 1'b0, 11'd0, 11'd0);
    wait_drained();

    // Merge size 1, mostly large empty grids: run the position past 16 bits
    write_config(20'($urandom()), 4'd1);
    add_random_tokens(160, 1'b1);
    wait_drained();

    // Largest start id, merge size 8
    write_config(20'hFFFFF, 4'd8);
    add_random_tokens(120, 1'b0);
    wait_drained();

    // Merge size 0 behaves as 1; grids of 1024 saturate to 1023
    write_config(20'($urandom()), 4'd0);
    add_token(vsid_q, 1'b0, 1'b1, 11'd1024, 11'd0);
    add_token(vsid_q, 1'b0, 1'b1, 11'd3, 11'd2);
    repeat (6) add_token(20'($urandom()), 1'b0, 1'($urandom()), 11'd0, 11'd0);
    add_token(vsid_q, 1'b0, 1'b1, 11'd0, 11'd1024);
    add_random_tokens(120, 1'b0);
    wait_drained();

    // Start id 0 again, odd merge size
    write_config(20'h00000, 4'd3);
    add_random_tokens(120, 1'b0);
    wait_drained();

    // Random settings
    write_config(20'($urandom()), 4'($urandom_range(1, 8)));
    add_random_tokens(120, 1'b0);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_ids.size() != 0) errors++;
    if (errors == 0) begin
      $display("multimodal_position_ids_tb: done, clean");
    end else begin
      $display("multimodal_position_ids_tb: done, errors");
    end
    $finish;
  end

endmodule
